>>> hw/rtl/graph_coloring_backtrack_top_defines.svh
// Assertion macros shared by the graph colouring block.
`ifndef GRAPH_COLORING_BACKTRACK_TOP_DEFINES_SVH
`define GRAPH_COLORING_BACKTRACK_TOP_DEFINES_SVH

// Check cons in the same cycle as ante; off while reset is low.
`define GCB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante; off while reset is low.
`define GCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gcb_pkg.sv
// Shared constants and types of the graph colouring block.
`timescale 1ns / 1ps
`default_nettype none

package gcb_pkg;

    localparam int MAX_NODES  = 8;
    localparam int MAX_DEGREE = 8;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int SLOT_W     = $clog2(MAX_DEGREE);
    localparam int ADDR_W     = NODE_W + SLOT_W;
    localparam int ADJ_DEPTH  = MAX_NODES * MAX_DEGREE;
    localparam int COLOR_W    = 4;
    localparam int CAND_W     = COLOR_W + 1;
    localparam int CNT_W      = NODE_W + 1;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic       REQ_WRITE = 1'b0;
    localparam logic       REQ_SOLVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLORS = 1'd1;

    // Request to the shared compare unit.
    typedef struct packed {
        logic                ent_valid;
        logic [NODE_W-1:0]   ent_nb;
        logic [CNT_W-1:0]    node;
        logic [COLOR_W-1:0]  nb_color;
        logic [CAND_W-1:0]   cand;
        logic [CFG_W-1:0]    num_colors;
    } t_chk_req;

    // Answer of the shared compare unit.
    typedef struct packed {
        logic conflict;
        logic over;
    } t_chk_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/gcb_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module gcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/gcb_unit.sv
// Shared compare unit: neighbor conflict test and colour range test.
`timescale 1ns / 1ps
`default_nettype none

module gcb_unit (
    input  wire gcb_pkg::t_chk_req i_req,
    output      gcb_pkg::t_chk_rsp o_rsp
);

    // A neighbor blocks the candidate only if it is valid, already placed
    // (lower index) and holds the same colour.
    assign o_rsp.conflict = i_req.ent_valid
                         && ({1'b0, i_req.ent_nb} < i_req.node)
                         && ({1'b0, i_req.nb_color} == i_req.cand);

    assign o_rsp.over = i_req.cand > {1'b0, i_req.num_colors};

endmodule

`default_nettype wire

>>> hw/rtl/graph_coloring_backtrack_top.sv
// Top level of the backtracking graph colouring block.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+-----------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: req_type; tdata: node_index,
//            |     |                               |   slot_index, neighbor_index, valid
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: out_node, out_color, solved;
//            |     |                               |   tlast: last
//  cfg       | in  | i_cfg_we (no wait)            | i_cfg_idx, i_cfg_data
//
// A solve visits each node in S_LOAD to load its colour, tests each candidate against the
// colour range in S_TRY, and scans each adjacency slot in S_RD (registered RAM read), then
// S_CHK (compare), up to MAX_DEGREE slots, stopping at the first conflict; the run time follows
// the search tree. Reset clears the adjacency valid bits at once. The request side is ready
// only while the sequencer idles; each result holds until the sink takes it, so the n results
// leave one per cycle at best.
`timescale 1ns / 1ps
`default_nettype none

`include "graph_coloring_backtrack_top_defines.svh"

module graph_coloring_backtrack_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [gcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [gcb_pkg::CFG_W-1:0]     i_cfg_data,
    // request stream
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,  // node[2:0] slot[5:3] nb[8:6] valid[9]
    input  wire logic                          s_axis_tuser,  // req_type[0]
    // result stream
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output      logic [7:0]                    m_axis_tdata,  // node[2:0] color[6:3] solved[7]
    output      logic                          m_axis_tlast
);

    localparam int NODE_W  = gcb_pkg::NODE_W;
    localparam int SLOT_W  = gcb_pkg::SLOT_W;
    localparam int ADDR_W  = gcb_pkg::ADDR_W;
    localparam int COLOR_W = gcb_pkg::COLOR_W;
    localparam int CAND_W  = gcb_pkg::CAND_W;
    localparam int CNT_W   = gcb_pkg::CNT_W;
    localparam int CFG_W   = gcb_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_TRY,
        S_RD,
        S_CHK,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_num_nodes;
    logic [CFG_W-1:0]      r_num_colors;
    logic [CNT_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_k;
    logic [SLOT_W-1:0]     r_s;
    logic [CAND_W-1:0]     r_cand;
    logic [NODE_W-1:0]     r_i;
    logic                  r_ok;
    logic [COLOR_W-1:0]    r_colors [gcb_pkg::MAX_NODES];
    logic [gcb_pkg::ADJ_DEPTH-1:0] r_adj_valid;
    logic                  r_ent_valid;
    logic                  r_mvalid;
    logic [7:0]            r_mdata;
    logic                  r_mlast;

    logic                  w_in_acc;
    logic [NODE_W-1:0]     w_in_node;
    logic [SLOT_W-1:0]     w_in_slot;
    logic [NODE_W-1:0]     w_in_nb;
    logic                  w_in_nbv;
    logic                  w_adj_we;
    logic [ADDR_W-1:0]     w_adj_waddr;
    logic [ADDR_W-1:0]     w_adj_raddr;
    logic [NODE_W-1:0]     w_ent_nb;
    logic [NODE_W-1:0]     w_rd_node;
    logic [COLOR_W-1:0]    w_rd_color;
    logic [CNT_W-1:0]      n_n;
    logic [CNT_W-1:0]      n_k;
    logic                  w_out_last;
    logic                  w_searching;
    logic                  w_scanning;
    logic                  w_give_up;
    logic                  w_fail_out;
    gcb_pkg::t_chk_req     w_req;
    gcb_pkg::t_chk_rsp     w_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_in_node     = s_axis_tdata[2:0];
    assign w_in_slot     = s_axis_tdata[5:3];
    assign w_in_nb       = s_axis_tdata[8:6];
    assign w_in_nbv      = s_axis_tdata[9];

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;

    // Clamp the node count to 1..MAX_NODES.
    always_comb begin
        if (r_num_nodes == '0) begin
            n_n = CNT_W'(1);
        end else if ({1'b0, r_num_nodes} > (CFG_W + 1)'(gcb_pkg::MAX_NODES)) begin
            n_n = CNT_W'(gcb_pkg::MAX_NODES);
        end else begin
            n_n = CNT_W'(r_num_nodes);
        end
    end

    // Adjacency neighbor store; valid bits sit in flops so reset clears them.
    assign w_adj_we    = w_in_acc && (s_axis_tuser == gcb_pkg::REQ_WRITE);
    assign w_adj_waddr = {w_in_node, w_in_slot};
    assign w_adj_raddr = {r_k[NODE_W-1:0], r_s};

    gcb_ram #(
        .WIDTH (NODE_W),
        .DEPTH (gcb_pkg::ADJ_DEPTH)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (w_adj_we),
        .i_waddr (w_adj_waddr),
        .i_wdata (w_in_nb),
        .i_raddr (w_adj_raddr),
        .o_rdata (w_ent_nb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_valid <= '0;
        end else if (w_adj_we) begin
            r_adj_valid[w_adj_waddr] <= w_in_nbv;
        end
        r_ent_valid <= r_adj_valid[w_adj_raddr];
    end

    // One read port on the colour file: current node while loading, the
    // neighbor under test while checking, the output node otherwise.
    always_comb begin
        case (r_state)
            S_LOAD:  w_rd_node = r_k[NODE_W-1:0];
            S_CHK:   w_rd_node = w_ent_nb;
            default: w_rd_node = r_i;
        endcase
    end
    assign w_rd_color = r_colors[w_rd_node];

    assign w_req.ent_valid  = r_ent_valid;
    assign w_req.ent_nb     = w_ent_nb;
    assign w_req.node       = r_k;
    assign w_req.nb_color   = w_rd_color;
    assign w_req.cand       = r_cand;
    assign w_req.num_colors = r_num_colors;

    gcb_unit u_unit (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign n_k        = r_k + CNT_W'(1);
    assign w_out_last = ({1'b0, r_i} + CNT_W'(1)) == r_n;

    // Configuration registers: written whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes  <= CFG_W'(7);
            r_num_colors <= CFG_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gcb_pkg::CFG_NUM_NODES:  r_num_nodes  <= i_cfg_data;
                gcb_pkg::CFG_NUM_COLORS: r_num_colors <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: depth-first search, then stream out one result per node.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= 1'b0;
        end else begin
            // drop the taken result; the output state handles its own register
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (s_axis_tuser == gcb_pkg::REQ_SOLVE)) begin
                        r_n          <= n_n;
                        r_k          <= CNT_W'(1);
                        r_ok         <= 1'b1;
                        r_i          <= '0;
                        r_colors[0]  <= COLOR_W'(1);
                        r_colors[1]  <= '0;
                        if (n_n == CNT_W'(1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    // resume above the colour the node holds now
                    r_cand  <= {1'b0, w_rd_color} + CAND_W'(1);
                    r_state <= S_TRY;
                end
                S_TRY: begin
                    if (w_rsp.over) begin
                        r_colors[r_k[NODE_W-1:0]] <= '0;
                        if (r_k == CNT_W'(1)) begin
                            // backtracked past node 1: no colouring exists
                            r_ok    <= 1'b0;
                            r_i     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k - CNT_W'(1);
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_s     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_rsp.conflict) begin
                        r_cand  <= r_cand + CAND_W'(1);
                        r_state <= S_TRY;
                    end else if (r_s == SLOT_W'(gcb_pkg::MAX_DEGREE - 1)) begin
                        r_colors[r_k[NODE_W-1:0]] <= r_cand[COLOR_W-1:0];
                        if (n_k == r_n) begin
                            r_i     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_k                       <= n_k;
                            r_colors[n_k[NODE_W-1:0]] <= '0;
                            r_state                   <= S_LOAD;
                        end
                    end else begin
                        r_s     <= r_s + SLOT_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= {r_ok, (r_ok ? w_rd_color : COLOR_W'(0)), r_i};
                        r_mlast  <= w_out_last;
                        if (w_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + NODE_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_searching = (r_state == S_LOAD) || (r_state == S_TRY)
                      || (r_state == S_RD) || (r_state == S_CHK);
    assign w_scanning  = (r_state == S_RD) || (r_state == S_CHK);
    assign w_give_up   = (r_state == S_TRY) && w_rsp.over && (r_k == CNT_W'(1));
    assign w_fail_out  = m_axis_tvalid && !m_axis_tdata[7];

    // The search depth never runs past the node count.
    `GCB_ASSERT_NOW(a_depth_in_range, (r_state != S_IDLE), (r_k <= r_n), "depth past count")
    // Node 0 keeps colour 1 throughout the search.
    `GCB_ASSERT_NOW(a_root_color, w_searching, (r_colors[0] == COLOR_W'(1)), "root colour lost")
    // Slots are only scanned for a candidate within the colour range.
    `GCB_ASSERT_NOW(a_cand_range, w_scanning, (r_cand <= {1'b0, r_num_colors}), "cand too high")
    // Running out of colours on node 1 ends the search as a failure.
    `GCB_ASSERT_NEXT(a_fail_exit, w_give_up, (r_state == S_OUT && !r_ok), "failure not reported")
    // A failed search shows no colour.
    `GCB_ASSERT_NOW(a_fail_blank, w_fail_out, (m_axis_tdata[6:3] == 4'd0), "colour on failure")

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the backtracking graph coloring block.
`timescale 1ns / 1ps

module tb;
    import gcb_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_NODES   = 7;
    localparam int RESET_COLORS  = 4;
    localparam int DIR_ROWS      = 21;
    localparam int RANDOM_ITEMS  = 460;
    // Keep every random search small enough for a bounded run.
    localparam int COST_CAP      = 1200;
    localparam int NO_BUDGET     = 2147483647;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 50;
    // Each candidate scans up to MAX_DEGREE slots; allow a wide margin.
    localparam int WATCHDOG_LIMIT = COST_CAP * (2 * MAX_DEGREE + 2) * 4 + 2000;

    // Fields of an adjacency request, last field in the lowest bits.
    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] nb;
        logic [SLOT_W-1:0] slot;
        logic [NODE_W-1:0] node;
    } slot_write_t;

    typedef struct packed {
        logic [ADJ_DEPTH-1:0]             vld;
        logic [ADJ_DEPTH-1:0][NODE_W-1:0] nb;
    } adj_table_t;

    typedef struct packed {
        logic [MAX_NODES-1:0][COLOR_W-1:0] color;
        logic                              solved;
    } coloring_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [COLOR_W-1:0] color;
        logic               solved;
        logic               last;
    } color_result_t;

    typedef struct packed {
        logic                              req;
        slot_write_t                       w;
        logic                              set_cfg;
        logic [CFG_W-1:0]                  nodes_cfg;
        logic [CFG_W-1:0]                  colors_cfg;
        logic                              typed;
        logic [MAX_NODES-1:0][COLOR_W-1:0] typed_color;
        logic                              typed_ok;
    } directed_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    graph_coloring_backtrack_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow copy of the block state, kept in step with accepted requests.
    adj_table_t      pred_table;
    logic [CFG_W-1:0] pred_nodes;
    logic [CFG_W-1:0] pred_colors;
    color_result_t   pending_colors [$];
    int              fail_count = 0;
    int              items_sent = 0;

    // A solve row with a hand-written answer overrides the search for one solve.
    bit                                typed_pending = 1'b0;
    logic [MAX_NODES-1:0][COLOR_W-1:0] typed_color;
    logic                              typed_ok;

    // Idling controls shared by the sender and the receiver.
    bit quiet = 1'b0;
    int src_idle_pct = 20;
    int sink_idle_pct = 20;
    bit sink_hold_req = 1'b0;
    int sink_hold_cycles = 0;
    int sink_stall = 0;
    int stall_cycles = 0;

    function automatic int used_nodes(input logic [CFG_W-1:0] cfg);
        if (cfg == '0) return 1;
        if (int'(cfg) > MAX_NODES) return MAX_NODES;
        return int'(cfg);
    endfunction

    function automatic adj_table_t with_slot(input adj_table_t t, input slot_write_t w);
        t.vld[{w.node, w.slot}] = w.vld;
        t.nb[{w.node, w.slot}]  = w.nb;
        return t;
    endfunction

    // Depth-first coloring; returns the candidate tests plus node steps, stops past budget.
    function automatic int backtrack_colors(input adj_table_t tbl, input logic [CFG_W-1:0] nodes_cfg,
                                            input logic [CFG_W-1:0] colors_cfg, input int budget,
                                            output coloring_t res);
        int n, nc, k, c, s, idx, cost;
        bit placed, fits;
        n = used_nodes(nodes_cfg);
        nc = int'(colors_cfg);
        res = '0;
        res.color[0] = 4'd1;
        res.solved = 1'b1;
        k = 1;
        cost = 0;
        while (k < n && res.solved && cost <= budget) begin
            c = int'(res.color[k]) + 1;
            placed = 1'b0;
            while (!placed && c <= nc) begin
                fits = 1'b1;
                // Only lower-indexed neighbors are placed; the rest count as uncolored.
                for (s = 0; s < MAX_DEGREE; s++) begin
                    idx = k * MAX_DEGREE + s;
                    if (tbl.vld[idx] && int'(tbl.nb[idx]) < k
                        && int'(res.color[tbl.nb[idx]]) == c)
                        fits = 1'b0;
                end
                cost++;
                if (fits) placed = 1'b1;
                else c++;
            end
            cost++;
            if (placed) begin
                res.color[k] = c[COLOR_W-1:0];
                k++;
                if (k < n) res.color[k] = '0;
            end else begin
                res.color[k] = '0;
                k--;
                if (k == 0) begin
                    res.color = '0;
                    res.solved = 1'b0;
                end
            end
        end
        return cost;
    endfunction

    function automatic slot_write_t any_slot();
        logic [31:0] r;
        r = $urandom;
        return r[9:0];
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    function automatic directed_row_t row_write(input logic [2:0] node, input logic [2:0] slot,
                                                input logic [2:0] nb, input logic vld);
        directed_row_t r;
        r = '0;
        r.req = REQ_WRITE;
        r.w = '{vld: vld, nb: nb, slot: slot, node: node};
        return r;
    endfunction

    function automatic directed_row_t row_solve(input logic set_cfg, input logic [3:0] nodes,
                                                input logic [3:0] colors, input logic typed,
                                                input logic [31:0] color_exp, input logic ok);
        directed_row_t r;
        r = '0;
        r.req = REQ_SOLVE;
        r.set_cfg = set_cfg;
        r.nodes_cfg = nodes;
        r.colors_cfg = colors;
        r.typed = typed;
        r.typed_color = color_exp;
        r.typed_ok = ok;
        return r;
    endfunction

    // Check results first, then track configuration and requests accepted at this edge.
    always @(posedge i_clk) begin
        color_result_t got, want;
        coloring_t sol;
        int n;
        if (!i_rst_n) begin
            pred_table = '0;
            pred_nodes = 4'(RESET_NODES);
            pred_colors = 4'(RESET_COLORS);
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{node: m_axis_tdata[2:0], color: m_axis_tdata[6:3],
                        solved: m_axis_tdata[7], last: m_axis_tlast};
                if (pending_colors.size() == 0) begin
                    $error("result with nothing pending: tdata %h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = pending_colors.pop_front();
                    if (got.node != want.node) begin
                        $error("out_node: expected %0d, got %0d", want.node, got.node);
                        fail_count++;
                    end
                    if (got.color != want.color) begin
                        $error("out_color: expected %0d, got %0d", want.color, got.color);
                        fail_count++;
                    end
                    if (got.solved != want.solved) begin
                        $error("solved: expected %0d, got %0d", want.solved, got.solved);
                        fail_count++;
                    end
                    if (got.last != want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_NUM_NODES) pred_nodes = i_cfg_data;
                else pred_colors = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == REQ_WRITE) begin
                    pred_table = with_slot(pred_table, s_axis_tdata[9:0]);
                end else begin
                    if (typed_pending) begin
                        sol.color = typed_color;
                        sol.solved = typed_ok;
                        typed_pending = 1'b0;
                    end else begin
                        void'(backtrack_colors(pred_table, pred_nodes, pred_colors,
                                               NO_BUDGET, sol));
                    end
                    n = used_nodes(pred_nodes);
                    for (int i = 0; i < n; i++) begin
                        want.node = 3'(i);
                        want.color = sol.color[i];
                        want.solved = sol.solved;
                        want.last = (i == n - 1);
                        pending_colors.push_back(want);
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off counted here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            m_axis_tready <= 1'b0;
        end else if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            sink_hold_cycles = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
            sink_stall = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** graph_coloring_backtrack_top: FAILED **");
            $finish;
        end
    end

    // Offer one request, after an optional idle burst; return once it is accepted.
    task automatic send_request(input logic req, input slot_write_t w);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {6'd0, w};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Drop valid and hold until every pending result is out, then let the block settle.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges; call only while the block idles.
    task automatic load_config(input logic [CFG_W-1:0] nodes, input logic [CFG_W-1:0] colors);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NUM_NODES;
        i_cfg_data <= nodes;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NUM_COLORS;
        i_cfg_data <= colors;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    directed_row_t    dir_rows [DIR_ROWS];
    adj_table_t       shadow;
    coloring_t        probe;
    slot_write_t      plan [$];
    slot_write_t      w;
    logic [5:0]       pick;
    logic [CFG_W-1:0] nodes_cfg, colors_cfg;
    int               phase, n_solves, nn, r;
    bit               pressure;

    initial begin
        // Reset values first: empty graph, seven nodes, four colors.
        dir_rows[0]  = row_solve(1'b0, 4'd0,  4'd0,  1'b1, 32'h0111_1111, 1'b1);
        dir_rows[1]  = row_solve(1'b1, 4'd1,  4'd0,  1'b1, 32'h0000_0001, 1'b1);
        // No colors: node 0 still takes one, node 1 cannot.
        dir_rows[2]  = row_solve(1'b1, 4'd2,  4'd0,  1'b1, 32'h0000_0000, 1'b0);
        // Node count zero acts as one, above the table acts as the full table.
        dir_rows[3]  = row_solve(1'b1, 4'd0,  4'd15, 1'b1, 32'h0000_0001, 1'b1);
        dir_rows[4]  = row_solve(1'b1, 4'd15, 4'd15, 1'b1, 32'h1111_1111, 1'b1);
        // Triangle over nodes 0..2, plus field extremes and an invalid slot.
        dir_rows[5]  = row_write(3'd1, 3'd0, 3'd0, 1'b1);
        dir_rows[6]  = row_write(3'd2, 3'd7, 3'd0, 1'b1);
        dir_rows[7]  = row_write(3'd2, 3'd3, 3'd1, 1'b1);
        dir_rows[8]  = row_write(3'd7, 3'd7, 3'd7, 1'b1);
        dir_rows[9]  = row_write(3'd7, 3'd0, 3'd6, 1'b0);
        // One-sided edge in node 0's own list, and a neighbor not yet placed.
        dir_rows[10] = row_write(3'd0, 3'd0, 3'd3, 1'b1);
        dir_rows[11] = row_write(3'd2, 3'd4, 3'd5, 1'b1);
        dir_rows[12] = row_solve(1'b1, 4'd3,  4'd2,  1'b1, 32'h0000_0000, 1'b0);
        dir_rows[13] = row_solve(1'b1, 4'd3,  4'd3,  1'b1, 32'h0000_0321, 1'b1);
        dir_rows[14] = row_solve(1'b1, 4'd4,  4'd3,  1'b0, 32'h0, 1'b0);
        // Clear one edge of the triangle, then solve with two colors again.
        dir_rows[15] = row_write(3'd1, 3'd0, 3'd0, 1'b0);
        dir_rows[16] = row_solve(1'b1, 4'd3,  4'd2,  1'b0, 32'h0, 1'b0);
        // Upper nodes that force backtracking over the whole set.
        dir_rows[17] = row_write(3'd7, 3'd1, 3'd5, 1'b1);
        dir_rows[18] = row_write(3'd7, 3'd2, 3'd6, 1'b1);
        dir_rows[19] = row_write(3'd6, 3'd0, 3'd5, 1'b1);
        dir_rows[20] = row_solve(1'b1, 4'd8,  4'd2,  1'b0, 32'h0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].set_cfg || dir_rows[i].typed) wait_results_drained();
            if (dir_rows[i].set_cfg) load_config(dir_rows[i].nodes_cfg, dir_rows[i].colors_cfg);
            if (dir_rows[i].typed) begin
                typed_color = dir_rows[i].typed_color;
                typed_ok = dir_rows[i].typed_ok;
                typed_pending = 1'b1;
            end
            send_request(dir_rows[i].req, dir_rows[i].w);
        end

        // Random phases: pick a setting at idle, grow the graph, then solve it.
        phase = 0;
        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            pressure = (phase == 3);
            wait_results_drained();
            quiet = (items_sent > DIR_ROWS + RANDOM_ITEMS * 85 / 100);
            src_idle_pct = (quiet || pressure) ? 0 : pick_idle_pct();
            sink_idle_pct = quiet ? 0 : pick_idle_pct();

            // Mostly small graphs; now and then the full table or an out-of-range count.
            r = $urandom_range(0, 99);
            if (pressure) nodes_cfg = 4'd8;
            else if (r < 60) nodes_cfg = 4'($urandom_range(1, 5));
            else if (r < 85) nodes_cfg = 4'($urandom_range(6, 8));
            else if (r < 92) nodes_cfg = 4'd0;
            else nodes_cfg = 4'($urandom_range(9, 15));
            r = $urandom_range(0, 99);
            if (r < 10) colors_cfg = 4'd0;
            else if (r < 55) colors_cfg = 4'($urandom_range(1, 4));
            else if (r < 80) colors_cfg = 4'($urandom_range(5, 8));
            else colors_cfg = 4'($urandom_range(9, 15));
            load_config(nodes_cfg, colors_cfg);

            // Plan the writes on a copy so the search stays within bounds.
            shadow = pred_table;
            plan.delete();
            nn = used_nodes(nodes_cfg);
            repeat ($urandom_range(0, 8)) begin
                w = any_slot();
                if (nn > 1 && $urandom_range(0, 99) < 75) begin
                    w.node = 3'($urandom_range(1, nn - 1));
                    w.nb = 3'($urandom_range(0, int'(w.node) - 1));
                    w.vld = ($urandom_range(0, 99) < 80);
                end
                plan.push_back(w);
                shadow = with_slot(shadow, w);
            end
            // Thin out the graph until a search fits in the budget.
            while (backtrack_colors(shadow, nodes_cfg, colors_cfg, COST_CAP, probe) > COST_CAP)
            begin
                pick = 6'($urandom_range(0, ADJ_DEPTH - 1));
                if (shadow.vld[pick]) begin
                    w = '{vld: 1'b0, nb: shadow.nb[pick], slot: pick[2:0], node: pick[5:3]};
                    plan.push_back(w);
                    shadow = with_slot(shadow, w);
                end
            end

            foreach (plan[i]) send_request(REQ_WRITE, plan[i]);
            // Under pressure the receiver holds off while solves keep coming.
            if (pressure) begin
                sink_hold_req = 1'b1;
                n_solves = 3;
            end else begin
                n_solves = ($urandom_range(0, 99) < 25) ? 2 : 1;
            end
            repeat (n_solves) send_request(REQ_SOLVE, any_slot());
            // Stray writes behind the solve land in the next phase's graph.
            repeat ($urandom_range(0, 2)) send_request(REQ_WRITE, any_slot());
            phase++;
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_colors.size() == 0) begin
            $display("** graph_coloring_backtrack_top: PASSED **");
        end else begin
            $display("** graph_coloring_backtrack_top: FAILED **");
        end
        $finish;
    end

endmodule
